FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds whenever ante holds.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Check that cond never holds.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: rtl/fdnt_pkg.sv
// ----------------------------------------------------------------------------
// fdnt_pkg
// Types, constants and helpers shared by the directory name table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdnt_pkg;

  localparam int ENTRIES         = 64;
  localparam int SLOT_BITS       = $clog2(ENTRIES);
  localparam int NAME_BYTES      = 8;
  localparam int NAME_BITS       = 8 * NAME_BYTES;
  localparam int IN_NAME_BITS    = 64;
  localparam int SECTOR_BITS     = 10;
  localparam int IN_SECTOR_BITS  = 10;
  localparam int SECTOR_OUT_BITS = 10;
  localparam int SLOT_OUT_BITS   = 6;

  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_IS_DIR    = 3'd4;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [NAME_BITS-1:0]   name;
    logic [SECTOR_BITS-1:0] sector;
    logic                   kind;
    logic                   files_only;
  } req_t;

  typedef struct packed {
    logic                   kind;
    logic [SECTOR_BITS-1:0] sector;
    logic [NAME_BITS-1:0]   name;
  } ent_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic [SECTOR_OUT_BITS-1:0] found_sector;
    logic [SLOT_OUT_BITS-1:0]   slot_index;
  } res_t;

  // Keep the low NAME_BYTES bytes and zero everything from the first NUL on.
  function automatic logic [NAME_BITS-1:0] canon_name(input logic [IN_NAME_BITS-1:0] raw);
    logic [NAME_BITS-1:0] acc;
    logic                 ended;
    acc   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        acc[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fdnt_mem.sv
// ----------------------------------------------------------------------------
// fdnt_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnt_mem
  import fdnt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [SLOT_BITS-1:0] waddr,
  input  wire ent_t                 wdata,
  input  wire logic [SLOT_BITS-1:0] raddr,
  output ent_t                      rdata
);

  ent_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/fdnt_cmp.sv
// ----------------------------------------------------------------------------
// fdnt_cmp
// Shared name comparator used once per scanned slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnt_cmp
  import fdnt_pkg::*;
(
  input  wire logic                 live,
  input  wire logic [NAME_BITS-1:0] stored,
  input  wire logic [NAME_BITS-1:0] key,
  output logic                      match
);

  // Only a live, valid slot may match; stale names are ignored.
  assign match = live && (stored == key);

endmodule

`default_nettype wire

FILE: rtl/fdnt_scan.sv
// ----------------------------------------------------------------------------
// fdnt_scan
// Sequencer that sweeps all slots through the shared comparator and commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnt_scan
  import fdnt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  input  wire logic out_free,
  output logic      done,
  output res_t      res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]             state;
  logic [SLOT_BITS:0]     idx;
  logic                   chk_live;
  logic [SLOT_BITS-1:0]   chk_idx;
  req_t                   cur;
  logic                   hit_found;
  logic [SLOT_BITS-1:0]   hit_slot;
  logic [SECTOR_BITS-1:0] hit_sector;
  logic                   hit_kind;
  logic                   free_found;
  logic [SLOT_BITS-1:0]   free_slot;
  logic [ENTRIES-1:0]     slot_valid;

  logic issue;
  logic match;
  logic do_write;
  logic do_clear;
  ent_t rd_ent;
  ent_t wr_ent;

  assign issue  = (state == S_SCAN) && (idx < (SLOT_BITS+1)'(ENTRIES));
  assign wr_ent = '{kind: cur.kind, sector: cur.sector, name: cur.name};

  fdnt_mem u_mem (
    .clk   (clk),
    .we    (done && do_write),
    .waddr (free_slot),
    .wdata (wr_ent),
    .raddr (idx[SLOT_BITS-1:0]),
    .rdata (rd_ent)
  );

  fdnt_cmp u_cmp (
    .live   (chk_live && slot_valid[chk_idx]),
    .stored (rd_ent.name),
    .key    (cur.name),
    .match  (match)
  );

  always_comb begin
    res          = '0;
    res.status   = ST_NOT_FOUND;
    do_write     = 1'b0;
    do_clear     = 1'b0;
    case (cur.req_type)
      REQ_FIND: begin
        if (hit_found) begin
          res.status       = ST_OK;
          res.found_sector = SECTOR_OUT_BITS'(hit_sector);
          res.slot_index   = SLOT_OUT_BITS'(hit_slot);
        end
      end
      REQ_ADD: begin
        if (hit_found) begin
          res.status     = ST_DUPLICATE;
          res.slot_index = SLOT_OUT_BITS'(hit_slot);
        end else if (free_found) begin
          res.status     = ST_OK;
          res.slot_index = SLOT_OUT_BITS'(free_slot);
          do_write       = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (hit_found) begin
          res.slot_index = SLOT_OUT_BITS'(hit_slot);
          if (cur.files_only && hit_kind) begin
            res.status = ST_IS_DIR;
          end else begin
            res.status = ST_OK;
            do_clear   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign done = (state == S_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chk_live   <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      slot_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= req;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          chk_live <= issue;
          chk_idx  <= idx[SLOT_BITS-1:0];
          if (chk_live) begin
            if (match && !hit_found) begin
              hit_found  <= 1'b1;
              hit_slot   <= chk_idx;
              hit_sector <= rd_ent.sector;
              hit_kind   <= rd_ent.kind;
            end
            if (!slot_valid[chk_idx] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= chk_idx;
            end
            if (chk_idx == SLOT_BITS'(ENTRIES - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // Hold here until the output register can take the result.
          if (out_free) begin
            if (do_write) begin
              slot_valid[free_slot] <= 1'b1;
            end
            if (do_clear) begin
              slot_valid[hit_slot] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fixed_directory_name_table_core.sv
// ----------------------------------------------------------------------------
// Fixed directory name table
// Find, add and remove requests against a 64-slot table of named entries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ group, one transfer per request; results leave
//   on the m_ group, exactly one transfer per request, in request order.
//   Every request sweeps all 64 slots through one shared name comparator,
//   reading the slot store one entry per cycle, so the slot count of the store
//   sets how long a request takes from its input transfer to its result
//   showing on m_tvalid. A new request is taken only after the sweep of the
//   last one has handed off its result.
//   s_tready is low while a request is in the sweep. A finished result sits in
//   the output register, and the next request is taken while it waits. If the
//   receiver stalls, the following sweep completes and then holds its result
//   until the output register drains.
//   Reset clears all slot valid marks at once, so the table starts empty with
//   no clearing pass; slot contents are only used after being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fixed_directory_name_table_core
  import fdnt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,  // [63:0] entry_name, [73:64] entry_sector,
                                     // [74] entry_kind, [79:75] zero
  input  wire logic [2:0]  s_tuser,  // [1:0] req_type, [2] files_only
  // Result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // [9:0] found_sector, [15:10] slot_index
  output logic [2:0]       m_tuser   // [2:0] status
);

  logic busy;
  logic in_xfer;
  logic out_free;
  logic scan_done;
  req_t req_in;
  res_t scan_res;

  // Take a new request only when no sweep is running.
  assign s_tready = !busy;
  assign in_xfer  = s_tvalid && s_tready;
  // The output register can load when empty or draining this cycle.
  assign out_free = !m_tvalid || m_tready;

  // Unpack the request and bring the name to canonical form on the way in.
  always_comb begin
    req_in.req_type   = s_tuser[1:0];
    req_in.files_only = s_tuser[2];
    req_in.name       = canon_name(s_tdata[IN_NAME_BITS-1:0]);
    req_in.sector     = SECTOR_BITS'(s_tdata[IN_NAME_BITS +: IN_SECTOR_BITS]);
    req_in.kind       = s_tdata[IN_NAME_BITS + IN_SECTOR_BITS];
  end

  fdnt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .req      (req_in),
    .out_free (out_free),
    .done     (scan_done),
    .res      (scan_res)
  );

  // Busy from request transfer until the sweep hands off its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_xfer) begin
      busy <= 1'b1;
    end else if (scan_done) begin
      busy <= 1'b0;
    end
  end

  // Output register: load on hand-off, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (scan_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      m_tdata <= {scan_res.slot_index, scan_res.found_sector};
      m_tuser <= scan_res.status;
    end
  end

  // A result must never overwrite one that is still waiting.
  `ASSERT_NEVER(a_no_overwrite, clk, rst, scan_done && m_tvalid && !m_tready)
  // A request transfer starts a sweep, so the next cycle must not take another.
  `ASSERT_IMP(a_one_at_a_time, clk, rst, in_xfer, ##1 !s_tready)
  // A new result only appears after the sweep hands one off.
  `ASSERT_IMP(a_result_source, clk, rst, $rose(m_tvalid), $past(scan_done))

endmodule

`default_nettype wire
